/* src/trpe_pkg.sv */
// Shared types, constants and helper functions of the touch report to pointer event block.
`default_nettype none
package trpe_pkg;

   localparam int unsigned RAW_W      = 16;
   localparam int unsigned POS_W      = 12;
   localparam int unsigned PROD_W     = RAW_W + POS_W;
   localparam int unsigned DIV_STEPS  = PROD_W;
   localparam int unsigned STEP_CNT_W = $clog2(DIV_STEPS);
   localparam int unsigned CSR_IDX_W  = 3;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [RAW_W-1:0] CMD_PRESSED  = 16'h01AA;
   localparam logic [RAW_W-1:0] CMD_RELEASED = 16'h00AA;

   localparam logic [RAW_W-1:0] ZERO_X_RESET    = 16'd140;
   localparam logic [RAW_W-1:0] ZERO_Y_RESET    = 16'd370;
   localparam logic [RAW_W-1:0] FULL_X_RESET    = 16'd3944;
   localparam logic [RAW_W-1:0] FULL_Y_RESET    = 16'd3907;
   localparam logic [POS_W-1:0] SPAN_X_RESET    = 12'd799;
   localparam logic [POS_W-1:0] SPAN_Y_RESET    = 12'd480;
   localparam logic [POS_W-1:0] DEAD_BAND_RESET = 12'd3;

   typedef enum logic [1:0] {
      EV_KIND_X    = 2'd0,
      EV_KIND_Y    = 2'd1,
      EV_KIND_SYNC = 2'd2,
      EV_KIND_BTN  = 2'd3
   } event_kind_type;

   typedef enum logic [1:0] {
      CMD_OTHER   = 2'd0,
      CMD_PRESS   = 2'd1,
      CMD_RELEASE = 2'd2
   } cmd_class_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ZERO_X    = 3'd0,
      REG_ZERO_Y    = 3'd1,
      REG_FULL_X    = 3'd2,
      REG_FULL_Y    = 3'd3,
      REG_SPAN_X    = 3'd4,
      REG_SPAN_Y    = 3'd5,
      REG_DEAD_BAND = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [RAW_W-1:0] zero_x;
      logic [RAW_W-1:0] zero_y;
      logic [RAW_W-1:0] full_x;
      logic [RAW_W-1:0] full_y;
      logic [POS_W-1:0] span_out_x;
      logic [POS_W-1:0] span_out_y;
      logic [POS_W-1:0] dead_band;
   } cfg_type;

   typedef struct packed {
      cmd_class_type    cmd_class;
      logic [RAW_W-1:0] raw_x;
      logic [RAW_W-1:0] raw_y;
   } item_type;

   typedef struct packed {
      logic [RAW_W-1:0] raw;
      logic [RAW_W-1:0] zero;
      logic [RAW_W-1:0] full;
      logic [POS_W-1:0] span;
      logic [POS_W-1:0] held;
      logic [POS_W-1:0] dead_band;
   } axis_req_type;

   function automatic logic [RAW_W-1:0] swap16(input logic [RAW_W-1:0] word);
      return {word[7:0], word[15:8]};
   endfunction

endpackage
`default_nettype wire

/* src/trpe_req_if.sv */
// Request channel carrying one touch report.
`default_nettype none
interface trpe_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] cmd_word;
   logic [15:0] raw_x_word;
   logic [15:0] raw_y_word;

   modport source (output valid, output cmd_word, output raw_x_word, output raw_y_word,
                   input ready);
   modport sink   (input valid, input cmd_word, input raw_x_word, input raw_y_word,
                   output ready);
endinterface
`default_nettype wire

/* src/trpe_rsp_if.sv */
// Response channel carrying one pointer event.
`default_nettype none
interface trpe_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [11:0] event_value;
   logic        last_event;

   modport source (output valid, output event_kind, output event_value, output last_event,
                   input ready);
   modport sink   (input valid, input event_kind, input event_value, input last_event,
                   output ready);
endinterface
`default_nettype wire

/* src/trpe_csr_if.sv */
// Configuration write channel.
`default_nettype none
interface trpe_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/trpe_front.sv */
// Front end: takes a touch report, byte-swaps the coordinates and classifies the command.
`default_nettype none
module trpe_front (
   trpe_req_if.sink           req,
   output logic               push_valid,
   input  logic               push_ready,
   output trpe_pkg::item_type push_item
);

   trpe_pkg::cmd_class_type cmd_class;

   always_comb begin
      case (req.cmd_word)
         trpe_pkg::CMD_PRESSED:  cmd_class = trpe_pkg::CMD_PRESS;
         trpe_pkg::CMD_RELEASED: cmd_class = trpe_pkg::CMD_RELEASE;
         default:                cmd_class = trpe_pkg::CMD_OTHER;
      endcase
   end

   assign push_valid          = req.valid;
   assign req.ready           = push_ready;
   assign push_item.cmd_class = cmd_class;
   assign push_item.raw_x     = trpe_pkg::swap16(req.raw_x_word);
   assign push_item.raw_y     = trpe_pkg::swap16(req.raw_y_word);

endmodule
`default_nettype wire

/* src/trpe_queue.sv */
// Small register queue between the front end and the back end.
`default_nettype none
module trpe_queue #(
   parameter int unsigned DEPTH = trpe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  trpe_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output trpe_pkg::item_type pop_item
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   trpe_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

/* src/trpe_axis.sv */
// One axis: offset removal, scaling by a multiply and a bit-serial divide, range and dead band.
`default_nettype none
module trpe_axis (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  trpe_pkg::axis_req_type         req,
   output logic                           done,
   output logic [trpe_pkg::POS_W-1:0]     result
);

   localparam int unsigned RAW_W  = trpe_pkg::RAW_W;
   localparam int unsigned POS_W  = trpe_pkg::POS_W;
   localparam int unsigned PROD_W = trpe_pkg::PROD_W;
   localparam int unsigned CNT_W  = trpe_pkg::STEP_CNT_W;

   typedef enum logic [3:0] {
      AX_IDLE = 4'b0001,
      AX_MUL  = 4'b0010,
      AX_DIV  = 4'b0100,
      AX_FIN  = 4'b1000
   } axis_state_type;

   axis_state_type    state_ff, state_in;
   logic [RAW_W-1:0]  diff_mag_ff, diff_mag_in;
   logic [RAW_W-1:0]  den_mag_ff, den_mag_in;
   logic              neg_ff, neg_in;
   logic              den_zero_ff, den_zero_in;
   logic [POS_W-1:0]  span_ff, span_in;
   logic [POS_W-1:0]  held_ff, held_in;
   logic [POS_W-1:0]  band_ff, band_in;
   logic [PROD_W-1:0] num_ff, num_in;
   logic [RAW_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic [RAW_W:0]    diff, den, rem_sh, rem_sub;
   logic              rem_ge;
   logic [PROD_W-1:0] product;
   logic [POS_W-1:0]  quo_low, delta;
   logic              positive, in_range, take;

   assign diff    = {1'b0, req.raw} - {1'b0, req.zero};
   assign den     = {1'b0, req.full} - {1'b0, req.zero};
   assign product = diff_mag_ff * span_ff;

   // One quotient bit per cycle: the numerator register shifts left and takes the quotient bits.
   assign rem_sh  = {rem_ff, num_ff[PROD_W-1]};
   assign rem_ge  = (rem_sh >= {1'b0, den_mag_ff});
   assign rem_sub = rem_sh - {1'b0, den_mag_ff};

   // Quotient sign comes from the operand signs; a zero magnitude is never above zero.
   assign positive = !neg_ff && (num_ff != '0);
   assign in_range = (num_ff <= PROD_W'(span_ff));
   assign quo_low  = num_ff[POS_W-1:0];
   assign delta    = (quo_low >= held_ff) ? (quo_low - held_ff) : (held_ff - quo_low);
   assign take     = !den_zero_ff && positive && in_range && (delta >= band_ff);

   assign done   = (state_ff == AX_FIN);
   assign result = take ? quo_low : held_ff;

   always_comb begin
      state_in    = state_ff;
      diff_mag_in = diff_mag_ff;
      den_mag_in  = den_mag_ff;
      neg_in      = neg_ff;
      den_zero_in = den_zero_ff;
      span_in     = span_ff;
      held_in     = held_ff;
      band_in     = band_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      case (state_ff)
         AX_IDLE: begin
            if (start) begin
               diff_mag_in = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
               den_mag_in  = den[RAW_W] ? RAW_W'(-den) : den[RAW_W-1:0];
               neg_in      = diff[RAW_W] ^ den[RAW_W];
               den_zero_in = (den == '0);
               span_in     = req.span;
               held_in     = req.held;
               band_in     = req.dead_band;
               state_in    = AX_MUL;
            end
         end
         AX_MUL: begin
            num_in   = product;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = AX_DIV;
         end
         AX_DIV: begin
            num_in = {num_ff[PROD_W-2:0], rem_ge};
            rem_in = rem_ge ? rem_sub[RAW_W-1:0] : rem_sh[RAW_W-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(trpe_pkg::DIV_STEPS - 1)) begin
               state_in = AX_FIN;
            end
         end
         AX_FIN: begin
            state_in = AX_IDLE;
         end
         default: begin
            state_in = AX_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AX_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_mag_ff <= diff_mag_in;
      den_mag_ff  <= den_mag_in;
      neg_ff      <= neg_in;
      den_zero_ff <= den_zero_in;
      span_ff     <= span_in;
      held_ff     <= held_in;
      band_ff     <= band_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
   end

endmodule
`default_nettype wire

/* src/trpe_back.sv */
// Back end: runs both axes, keeps position and button state, and sends out the event list.
`default_nettype none
module trpe_back (
   input  logic               clock,
   input  logic               reset,
   input  trpe_pkg::cfg_type  cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  trpe_pkg::item_type pop_item,
   trpe_rsp_if.source         rsp
);

   localparam int unsigned POS_W = trpe_pkg::POS_W;

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_CALC = 3'b010,
      BK_EMIT = 3'b100
   } back_state_type;

   typedef enum logic [4:0] {
      ST_X    = 5'b00001,
      ST_Y    = 5'b00010,
      ST_SYNC = 5'b00100,
      ST_BTN  = 5'b01000,
      ST_LAST = 5'b10000
   } step_type;

   back_state_type          state_ff, state_in;
   step_type                step_ff, step_in;
   logic [POS_W-1:0]        pos_x_ff, pos_x_in;
   logic [POS_W-1:0]        pos_y_ff, pos_y_in;
   logic                    latch_ff, latch_in;
   logic                    btn_emit_ff, btn_emit_in;
   logic                    btn_value_ff, btn_value_in;
   trpe_pkg::cmd_class_type cls_ff, cls_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_kind_ff, rsp_kind_in;
   logic [POS_W-1:0]        rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    start, out_free;
   trpe_pkg::axis_req_type  x_req, y_req;
   logic                    x_done, y_done;
   logic [POS_W-1:0]        x_result, y_result;

   assign x_req.raw       = pop_item.raw_x;
   assign x_req.zero      = cfg.zero_x;
   assign x_req.full      = cfg.full_x;
   assign x_req.span      = cfg.span_out_x;
   assign x_req.held      = pos_x_ff;
   assign x_req.dead_band = cfg.dead_band;

   assign y_req.raw       = pop_item.raw_y;
   assign y_req.zero      = cfg.zero_y;
   assign y_req.full      = cfg.full_y;
   assign y_req.span      = cfg.span_out_y;
   assign y_req.held      = pos_y_ff;
   assign y_req.dead_band = cfg.dead_band;

   trpe_axis u_axis_x (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (x_req),
      .done   (x_done),
      .result (x_result)
   );

   trpe_axis u_axis_y (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (y_req),
      .done   (y_done),
      .result (y_result)
   );

   assign pop_ready = (state_ff == BK_IDLE);
   assign start     = pop_ready && pop_valid;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.event_kind  = rsp_kind_ff;
   assign rsp.event_value = rsp_value_ff;
   assign rsp.last_event  = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      latch_in     = latch_ff;
      btn_emit_in  = btn_emit_ff;
      btn_value_in = btn_value_ff;
      cls_in       = cls_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         BK_IDLE: begin
            if (start) begin
               cls_in   = pop_item.cmd_class;
               state_in = BK_CALC;
            end
         end
         BK_CALC: begin
            // Both axes run the same number of cycles, so they finish together.
            if (x_done && y_done) begin
               pos_x_in    = x_result;
               pos_y_in    = y_result;
               step_in     = ((x_result != '0) && (y_result != '0)) ? ST_X : ST_SYNC;
               btn_emit_in = 1'b0;
               btn_value_in = 1'b0;
               case (cls_ff)
                  trpe_pkg::CMD_PRESS: begin
                     if (!latch_ff) begin
                        latch_in     = 1'b1;
                        btn_emit_in  = 1'b1;
                        btn_value_in = 1'b1;
                     end
                  end
                  trpe_pkg::CMD_RELEASE: begin
                     latch_in    = 1'b0;
                     btn_emit_in = 1'b1;
                  end
                  default: begin
                     btn_emit_in = 1'b0;
                  end
               endcase
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_value_in = '0;
               case (step_ff)
                  ST_X: begin
                     rsp_kind_in  = trpe_pkg::EV_KIND_X;
                     rsp_value_in = pos_x_ff;
                     step_in      = ST_Y;
                  end
                  ST_Y: begin
                     rsp_kind_in  = trpe_pkg::EV_KIND_Y;
                     rsp_value_in = pos_y_ff;
                     step_in      = ST_SYNC;
                  end
                  ST_SYNC: begin
                     rsp_kind_in = trpe_pkg::EV_KIND_SYNC;
                     step_in     = btn_emit_ff ? ST_BTN : ST_LAST;
                  end
                  ST_BTN: begin
                     rsp_kind_in  = trpe_pkg::EV_KIND_BTN;
                     rsp_value_in = POS_W'(btn_value_ff);
                     step_in      = ST_LAST;
                  end
                  ST_LAST: begin
                     rsp_kind_in = trpe_pkg::EV_KIND_SYNC;
                     rsp_last_in = 1'b1;
                     state_in    = BK_IDLE;
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                     state_in     = BK_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         step_ff      <= ST_SYNC;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         latch_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         latch_ff     <= latch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      btn_emit_ff  <= btn_emit_in;
      btn_value_ff <= btn_value_in;
      cls_ff       <= cls_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule
`default_nettype wire

/* src/touch_report_to_pointer_events.sv */
// Top level: configuration registers, front end, request queue and back end.
`default_nettype none
// Turns touch reports into pointer events. Each request carries a command word and two
// byte-swapped raw coordinates; each axis is offset, scaled to its output span with a
// truncating signed divide, range checked and filtered by the dead band, and the request
// then yields two to five events (optional X and Y, sync, optional button, final sync
// marked last_event). In the back end a request is dispatched, multiplied, divided in
// the bit-serial divider each axis owns, settled into the position, and its events are
// sent one by one as the output takes them. A queue of QUEUE_DEPTH requests in front
// lets new reports be taken while events are still going out. Configuration is written
// through the csr channel, by the user only while idle; the block does not enforce this.
module touch_report_to_pointer_events #(
   parameter int unsigned QUEUE_DEPTH = trpe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   trpe_req_if.sink   req_ch,
   trpe_rsp_if.source rsp_ch,
   trpe_csr_if.sink   csr_ch
);

   trpe_pkg::cfg_type  cfg_ff, cfg_in;
   logic               push_valid, push_ready, pop_valid, pop_ready;
   trpe_pkg::item_type push_item, pop_item;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (trpe_pkg::reg_index_type'(csr_ch.index))
            trpe_pkg::REG_ZERO_X:    cfg_in.zero_x     = csr_ch.data;
            trpe_pkg::REG_ZERO_Y:    cfg_in.zero_y     = csr_ch.data;
            trpe_pkg::REG_FULL_X:    cfg_in.full_x     = csr_ch.data;
            trpe_pkg::REG_FULL_Y:    cfg_in.full_y     = csr_ch.data;
            trpe_pkg::REG_SPAN_X:    cfg_in.span_out_x = csr_ch.data[trpe_pkg::POS_W-1:0];
            trpe_pkg::REG_SPAN_Y:    cfg_in.span_out_y = csr_ch.data[trpe_pkg::POS_W-1:0];
            trpe_pkg::REG_DEAD_BAND: cfg_in.dead_band  = csr_ch.data[trpe_pkg::POS_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_x     <= trpe_pkg::ZERO_X_RESET;
         cfg_ff.zero_y     <= trpe_pkg::ZERO_Y_RESET;
         cfg_ff.full_x     <= trpe_pkg::FULL_X_RESET;
         cfg_ff.full_y     <= trpe_pkg::FULL_Y_RESET;
         cfg_ff.span_out_x <= trpe_pkg::SPAN_X_RESET;
         cfg_ff.span_out_y <= trpe_pkg::SPAN_Y_RESET;
         cfg_ff.dead_band  <= trpe_pkg::DEAD_BAND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   trpe_front u_front (
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   trpe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   trpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp       (rsp_ch)
   );

   // Only the closing sync of a request is marked last.
   a_last_is_sync: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.last_event |-> rsp_ch.event_kind == trpe_pkg::EV_KIND_SYNC)
      else $error("last_event set on an event that is not a sync");

   // A button event carries only a pressed or released flag.
   a_button_value: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.event_kind == trpe_pkg::EV_KIND_BTN
      |-> rsp_ch.event_value[trpe_pkg::POS_W-1:1] == '0)
      else $error("button event value is neither 0 nor 1");

   // Once an X event is taken, the Y event follows right behind it.
   a_x_then_y: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && rsp_ch.event_kind == trpe_pkg::EV_KIND_X
      |=> rsp_ch.valid && rsp_ch.event_kind == trpe_pkg::EV_KIND_Y)
      else $error("X event not followed by a Y event");

endmodule
`default_nettype wire
